// ===== hdl/led_matrix_char_scanner_core_defines.svh =====
// Assertion helpers shared by the checker file.
`ifndef LED_MATRIX_CHAR_SCANNER_CORE_DEFINES_SVH
`define LED_MATRIX_CHAR_SCANNER_CORE_DEFINES_SVH

// Check a property on every clock edge; hold off while reset is low.
`define LMCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check an implication on every clock edge; hold off while reset is low.
`define LMCS_ASSERT_IMP(lbl, ante, cons, msg) \
  `LMCS_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// ===== hdl/lmcs_pkg.sv =====
package lmcs_pkg;

  localparam int unsigned FONT_CHARS = 42;
  localparam int unsigned COLUMNS    = 5;
  localparam int unsigned ROWS       = 7;

  // op codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // data kinds
  localparam logic [1:0] KIND_ASCII = 2'd0;
  localparam logic [1:0] KIND_BIN   = 2'd1;
  localparam logic [1:0] KIND_DEC   = 2'd2;
  localparam logic [1:0] KIND_HEX   = 2'd3;

  // status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NO_ACCESS = 2'd1;
  localparam logic [1:0] STATUS_DISABLED  = 2'd2;
  localparam logic [1:0] STATUS_INVALID   = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_ACCESS  = 2'd0;
  localparam logic [1:0] REG_ENABLE  = 2'd1;
  localparam logic [1:0] REG_POLAR   = 2'd2;
  localparam logic [1:0] REG_PASSES  = 2'd3;

  localparam logic [7:0] PASSES_RESET = 8'd10;
  localparam logic [2:0] LAST_COLUMN  = 3'(COLUMNS - 1);

  typedef struct packed {
    logic       op;
    logic [1:0] data_kind;
    logic [7:0] value;
  } lmcs_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] column_index;
    logic [4:0] column_select;
    logic [6:0] row_drive;
    logic       lit;
  } lmcs_out_t;

endpackage

// ===== hdl/led_matrix_char_scanner_core.sv =====
// Column-scanned 5x7 LED dot-matrix driver. A load word (op 0) carries an ASCII digit or
// capital letter, or a binary, decimal or hex value that must lie below its base; a valid
// load stores the font code, restarts at column 0 and arms passes_cfg_q full scans. A
// tick word (op 1) returns one column: column_select with one line at its active level and
// row_drive with the font pattern at the wiring polarity (polar_q 0 common cathode,
// 1 common anode); with no passes left it returns blank levels and lit 0. Loads refused
// for access, enable or value return status 1, 2 or 3 and leave the display unchanged.
// One word is accepted every cycle while in_stall_o is low; its result word is registered
// in the output register, and the font ROM read is synchronous, addressed
// in the accept cycle while the scan state updates in the same edge, so a word may follow
// its predecessor directly. The output register stalls the input only while it is full
// and stalled itself. Configuration writes are always ready and should be made only
// while no word is in flight.
module led_matrix_char_scanner_core
  import lmcs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  lmcs_in_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output lmcs_out_t out_word_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  // Font ROM, one byte per column; bit 0 is the top row.
  localparam logic [7:0] FONT_ROM [FONT_CHARS][COLUMNS] = '{
    '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E}, '{8'h00, 8'h42, 8'h7F, 8'h40, 8'h00},
    '{8'h42, 8'h61, 8'h51, 8'h49, 8'h46}, '{8'h41, 8'h41, 8'h49, 8'h49, 8'h7F},
    '{8'h0F, 8'h08, 8'h08, 8'h08, 8'h7F}, '{8'h4F, 8'h49, 8'h49, 8'h49, 8'h79},
    '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h79}, '{8'h01, 8'h01, 8'h01, 8'h01, 8'h7F},
    '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h7F}, '{8'h4F, 8'h49, 8'h49, 8'h49, 8'h7F},
    '{8'h7E, 8'h09, 8'h09, 8'h09, 8'h7E}, '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h36},
    '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h22}, '{8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C},
    '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h63}, '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h01},
    '{8'h3E, 8'h41, 8'h41, 8'h49, 8'h7A}, '{8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F},
    '{8'h00, 8'h41, 8'h7F, 8'h41, 8'h00}, '{8'h20, 8'h40, 8'h41, 8'h3F, 8'h01},
    '{8'h7F, 8'h08, 8'h14, 8'h22, 8'h41}, '{8'h7F, 8'h40, 8'h40, 8'h40, 8'h60},
    '{8'h7F, 8'h02, 8'h04, 8'h02, 8'h7F}, '{8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F},
    '{8'h7F, 8'h41, 8'h41, 8'h41, 8'h7F}, '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h06},
    '{8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E}, '{8'h7F, 8'h09, 8'h19, 8'h29, 8'h46},
    '{8'h46, 8'h49, 8'h49, 8'h49, 8'h31}, '{8'h01, 8'h01, 8'h7F, 8'h01, 8'h01},
    '{8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F}, '{8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F},
    '{8'h3F, 8'h40, 8'h30, 8'h40, 8'h3F}, '{8'h63, 8'h14, 8'h08, 8'h14, 8'h63},
    '{8'h07, 8'h08, 8'h70, 8'h08, 8'h07}, '{8'h61, 8'h51, 8'h49, 8'h45, 8'h43},
    '{8'h24, 8'h2A, 8'h7F, 8'h2A, 8'h12}, '{8'h08, 8'h14, 8'h22, 8'h41, 8'h00},
    '{8'h41, 8'h22, 8'h14, 8'h08, 8'h00}, '{8'h14, 8'h14, 8'h14, 8'h14, 8'h14},
    '{8'h36, 8'h49, 8'h55, 8'h22, 8'h50}, '{8'h44, 8'h3C, 8'h04, 8'h7C, 8'h44}
  };

  // configuration registers
  logic       access_q, enable_q, polar_q;
  logic [7:0] passes_cfg_q;

  // scan state
  logic [5:0] code_q, code_d;
  logic [2:0] scan_col_q, scan_col_d;
  logic [7:0] passes_left_q, passes_left_d;

  // output register: result word with row pattern and column select still active-high
  logic       out_valid_q;
  logic [1:0] status_q, status_d;
  logic [2:0] col_idx_q, col_idx_d;
  logic [4:0] sel_q, sel_d;
  logic [6:0] pat_q;
  logic       lit_q, lit_d;
  logic       polar_out_q;

  logic       accept;
  logic [2:0] col_cur;
  logic       value_ok;
  logic [5:0] load_code;

  assign cfg_ready_o = 1'b1;

  // Accept whenever the output register is empty or drains this cycle.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      access_q     <= 1'b0;
      enable_q     <= 1'b0;
      polar_q      <= 1'b0;
      passes_cfg_q <= PASSES_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_ACCESS: access_q     <= cfg_data_i[0];
        REG_ENABLE: enable_q     <= cfg_data_i[0];
        REG_POLAR:  polar_q      <= cfg_data_i[0];
        REG_PASSES: passes_cfg_q <= cfg_data_i;
        default:    access_q     <= access_q;
      endcase
    end
  end

  // Decode the character or value of a load word into a font code.
  always_comb begin
    value_ok  = 1'b0;
    load_code = in_word_i.value[5:0];
    case (in_word_i.data_kind)
      KIND_ASCII: begin
        if (in_word_i.value >= 8'h30 && in_word_i.value <= 8'h39) begin
          value_ok  = 1'b1;
          load_code = 6'(in_word_i.value - 8'h30);
        end else if (in_word_i.value >= 8'h41 && in_word_i.value <= 8'h5A) begin
          value_ok  = 1'b1;
          load_code = 6'(in_word_i.value - 8'h37);
        end
      end
      KIND_BIN: value_ok = in_word_i.value < 8'd2;
      KIND_DEC: value_ok = in_word_i.value < 8'd10;
      KIND_HEX: value_ok = in_word_i.value < 8'd16;
      default:  value_ok = 1'b0;
    endcase
  end

  // Wrap a stray column back to 0 before use.
  assign col_cur = (scan_col_q > LAST_COLUMN) ? 3'd0 : scan_col_q;

  always_comb begin
    code_d        = code_q;
    scan_col_d    = scan_col_q;
    passes_left_d = passes_left_q;
    status_d      = STATUS_OK;
    col_idx_d     = 3'd0;
    sel_d         = 5'd0;
    lit_d         = 1'b0;
    if (in_word_i.op == OP_LOAD) begin
      if (!access_q) begin
        status_d = STATUS_NO_ACCESS;
      end else if (!enable_q) begin
        status_d = STATUS_DISABLED;
      end else if (!value_ok) begin
        status_d = STATUS_INVALID;
      end else begin
        code_d        = load_code;
        scan_col_d    = 3'd0;
        passes_left_d = passes_cfg_q;
      end
    end else begin
      col_idx_d  = col_cur;
      scan_col_d = col_cur;
      if (passes_left_q != 8'd0) begin
        lit_d = 1'b1;
        sel_d = 5'(1) << col_cur;
        if (col_cur == LAST_COLUMN) begin
          scan_col_d    = 3'd0;
          passes_left_d = passes_left_q - 8'd1;
        end else begin
          scan_col_d = col_cur + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q        <= 6'd0;
      scan_col_q    <= 3'd0;
      passes_left_q <= 8'd0;
      out_valid_q   <= 1'b0;
    end else begin
      if (accept) begin
        code_q        <= code_d;
        scan_col_q    <= scan_col_d;
        passes_left_q <= passes_left_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Font ROM read and output payload; a blank column reads as no dots lit.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q    <= status_d;
      col_idx_q   <= col_idx_d;
      sel_q       <= sel_d;
      lit_q       <= lit_d;
      polar_out_q <= polar_q;
      if (lit_d && (code_q < 6'(FONT_CHARS))) begin
        pat_q <= FONT_ROM[code_q][col_cur][6:0];
      end else begin
        pat_q <= 7'd0;
      end
    end
  end

  // Apply wiring polarity: anode wiring drives the column low and lit rows high.
  assign out_valid_o              = out_valid_q;
  assign out_word_o.status        = status_q;
  assign out_word_o.column_index  = col_idx_q;
  assign out_word_o.column_select = polar_out_q ? ~sel_q : sel_q;
  assign out_word_o.row_drive     = polar_out_q ? pat_q : ~pat_q;
  assign out_word_o.lit           = lit_q;

endmodule

// ===== hdl/lmcs_checker.sv =====
`include "led_matrix_char_scanner_core_defines.svh"

module lmcs_checker
  import lmcs_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input lmcs_out_t out_word_o
);

  // hold a stalled result word
  `LMCS_ASSERT_IMP(a_out_hold, out_valid_o && out_stall_i, ##1 (out_valid_o && $stable(out_word_o)), "stalled result word changed")

  // a lit column is a good tick inside the matrix
  `LMCS_ASSERT_IMP(a_lit_ok, out_valid_o && out_word_o.lit, (out_word_o.status == STATUS_OK) && (out_word_o.column_index <= 3'(COLUMNS - 1)), "lit column with bad status or index")

  // a lit column drives exactly one select line at its active level
  `LMCS_ASSERT_IMP(a_lit_sel, out_valid_o && out_word_o.lit, $onehot(out_word_o.column_select) || $onehot(~out_word_o.column_select), "lit column select not one-hot")

  // a blank word shows one of the two blank level sets
  `LMCS_ASSERT_IMP(a_blank, out_valid_o && !out_word_o.lit, (out_word_o.column_select == 5'h00 && out_word_o.row_drive == 7'h7F) || (out_word_o.column_select == 5'h1F && out_word_o.row_drive == 7'h00), "blank word with non-blank levels")

  // refused loads report column 0
  `LMCS_ASSERT_IMP(a_err_col, out_valid_o && (out_word_o.status != STATUS_OK), (out_word_o.column_index == 3'd0) && !out_word_o.lit, "refused load with column or lit set")

endmodule

bind led_matrix_char_scanner_core lmcs_checker u_lmcs_checker (.*);
